FILE: rtl/neighbor_channel_pair_finder_core_macros.svh
// Assertion macros shared by the neighbor channel pair finder RTL.
`ifndef NEIGHBOR_CHANNEL_PAIR_FINDER_CORE_MACROS_SVH
`define NEIGHBOR_CHANNEL_PAIR_FINDER_CORE_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define NCPF_ASSERT_IMPLY(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ncpf: same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define NCPF_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ncpf: next-cycle check failed");

`endif

FILE: rtl/ncpf_pkg.sv
// Types, constants and helper functions shared by the pair finder modules.
package ncpf_pkg;

   // Queue depths and derived widths.
   localparam int unsigned CMD_DEPTH   = 2;
   localparam int unsigned CMD_PTR_W   = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
   localparam int unsigned CMD_CNT_W   = $clog2(CMD_DEPTH + 1);
   localparam int unsigned RSP_DEPTH   = 2;
   localparam int unsigned RSP_PTR_W   = (RSP_DEPTH > 1) ? $clog2(RSP_DEPTH) : 1;
   localparam int unsigned RSP_CNT_W   = $clog2(RSP_DEPTH + 1);

   // Field widths.
   localparam int unsigned CHANNEL_W   = 16;
   localparam int unsigned CHARGE_W    = 32;
   localparam int unsigned TIMESTAMP_W = 64;
   localparam int unsigned WALL_W      = 32;
   localparam int unsigned WINDOW_W    = 32;
   localparam int unsigned COUNT_W     = 32;

   // Reset value of the time window register, in picoseconds.
   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 32'd25000;
   localparam logic [COUNT_W-1:0]  COUNT_MAX    = '1;

   // One detector hit.
   typedef struct packed {
      logic [CHANNEL_W-1:0]   channel;
      logic [CHARGE_W-1:0]    charge;
      logic [TIMESTAMP_W-1:0] timestamp;
      logic [WALL_W-1:0]      wall_time;
   } hit_type;

   // A candidate pair handed from the front to the back.
   typedef struct packed {
      hit_type                first_hit;
      hit_type                second_hit;
      logic [TIMESTAMP_W-1:0] gap;
      logic                   odd_bad;
   } pair_cmd_type;

   // One result item.
   typedef struct packed {
      hit_type            hit;
      logic               pair_last;
      logic [COUNT_W-1:0] odd_rejects;
      logic [COUNT_W-1:0] gap_rejects;
      logic [COUNT_W-1:0] total_rejects;
   } result_type;

   // Status of a queue as seen by its neighbors.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Back end sequencing: first hit of a pair, then second hit.
   typedef enum logic {
      BACK_FIRST,
      BACK_SECOND
   } back_state_type;

   // Saturating increment of a reject counter.
   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] value);
      logic [COUNT_W-1:0] result;
      result = (value == COUNT_MAX) ? value : value + 1'b1;
      return result;
   endfunction

endpackage

FILE: rtl/neighbor_channel_pair_finder_core.sv
// Top level of the neighbor channel pair finder.
// Hits enter at up to one per cycle; a hit is refused only while the two-entry pair
// queue between front and back is full. The front compares each hit with the pending
// hit in the same cycle. A pair whose channels differ by one goes to the back, which
// drops a rejected pair and turns an accepted pair into two result items, first hit
// then second hit, each held back while the result queue is full. The first item
// shows on the result ports once it has passed the pair queue and the result queue
// registers, or later behind older pairs. The reject counters in a result item are the
// counts at the time the pair was checked. The window register may be written at any
// time the block is idle; csr_ready is always high.
module neighbor_channel_pair_finder_core (
   input  logic                              clock,
   input  logic                              reset,
   // Input hits.
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [ncpf_pkg::CHANNEL_W-1:0]    req_hit_channel,
   input  logic [ncpf_pkg::CHARGE_W-1:0]     req_hit_charge,
   input  logic [ncpf_pkg::TIMESTAMP_W-1:0]  req_hit_timestamp,
   input  logic [ncpf_pkg::WALL_W-1:0]       req_hit_wall_time,
   // Result items.
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [ncpf_pkg::CHANNEL_W-1:0]    rsp_out_channel,
   output logic [ncpf_pkg::CHARGE_W-1:0]     rsp_out_charge,
   output logic [ncpf_pkg::TIMESTAMP_W-1:0]  rsp_out_timestamp,
   output logic [ncpf_pkg::WALL_W-1:0]       rsp_out_wall_time,
   output logic                              rsp_pair_last,
   output logic [ncpf_pkg::COUNT_W-1:0]      rsp_odd_rejects,
   output logic [ncpf_pkg::COUNT_W-1:0]      rsp_gap_rejects,
   output logic [ncpf_pkg::COUNT_W-1:0]      rsp_total_rejects,
   // Window register write.
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ncpf_pkg::WINDOW_W-1:0]     csr_time_window
);
   import ncpf_pkg::*;

   logic [WINDOW_W-1:0] window_ff;
   hit_type             hit;
   queue_status_type    cmd_status;
   queue_status_type    rsp_status;
   logic                cmd_push, cmd_pop;
   pair_cmd_type        cmd_data, cmd_head;
   logic                rsp_push;
   result_type          rsp_data, rsp_head;

   // Window register.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
      end else if (csr_valid && csr_ready) begin
         window_ff <= csr_time_window;
      end
   end

   // Gather the input hit.
   assign hit.channel   = req_hit_channel;
   assign hit.charge    = req_hit_charge;
   assign hit.timestamp = req_hit_timestamp;
   assign hit.wall_time = req_hit_wall_time;

   ncpf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .hit        (hit),
      .req_full   (req_full),
      .cmd_status (cmd_status),
      .cmd_push   (cmd_push),
      .cmd_data   (cmd_data)
   );

   ncpf_cmd_queue u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_data),
      .pop       (cmd_pop),
      .head      (cmd_head),
      .status    (cmd_status)
   );

   ncpf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .time_window (window_ff),
      .cmd_status  (cmd_status),
      .cmd_head    (cmd_head),
      .cmd_pop     (cmd_pop),
      .rsp_status  (rsp_status),
      .rsp_push    (rsp_push),
      .rsp_data    (rsp_data)
   );

   ncpf_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_data),
      .pop       (rsp_pop),
      .head      (rsp_head),
      .status    (rsp_status)
   );

   // Result ports show the oldest waiting item.
   assign rsp_empty         = rsp_status.empty;
   assign rsp_out_channel   = rsp_head.hit.channel;
   assign rsp_out_charge    = rsp_head.hit.charge;
   assign rsp_out_timestamp = rsp_head.hit.timestamp;
   assign rsp_out_wall_time = rsp_head.hit.wall_time;
   assign rsp_pair_last     = rsp_head.pair_last;
   assign rsp_odd_rejects   = rsp_head.odd_rejects;
   assign rsp_gap_rejects   = rsp_head.gap_rejects;
   assign rsp_total_rejects = rsp_head.total_rejects;

endmodule

FILE: rtl/ncpf_cmd_queue.sv
// Short queue of candidate pairs between the front and the back.
`include "neighbor_channel_pair_finder_core_macros.svh"

module ncpf_cmd_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  ncpf_pkg::pair_cmd_type       push_data,
   input  logic                         pop,
   output ncpf_pkg::pair_cmd_type       head,
   output ncpf_pkg::queue_status_type   status
);
   import ncpf_pkg::*;

   pair_cmd_type         entry_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0] count_ff, count_in;
   logic                 do_push, do_pop;

   // Status and head of the queue.
   assign status.full  = (count_ff == CMD_CNT_W'(CMD_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head         = entry_ff[rd_ptr_ff];

   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `NCPF_ASSERT_IMPLY(cmd_count_in_range, 1'b1, count_ff <= CMD_CNT_W'(CMD_DEPTH))

endmodule

FILE: rtl/ncpf_rsp_queue.sv
// Output queue holding result items until the consumer pops them.
module ncpf_rsp_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  ncpf_pkg::result_type         push_data,
   input  logic                         pop,
   output ncpf_pkg::result_type         head,
   output ncpf_pkg::queue_status_type   status
);
   import ncpf_pkg::*;

   result_type           entry_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic                 do_push, do_pop;

   // Status and head of the queue.
   assign status.full  = (count_ff == RSP_CNT_W'(RSP_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head         = entry_ff[rd_ptr_ff];

   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == RSP_PTR_W'(RSP_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == RSP_PTR_W'(RSP_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/ncpf_front.sv
// Front end: holds the pending hit, detects neighbor channels and forms pairs.
`include "neighbor_channel_pair_finder_core_macros.svh"

module ncpf_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   input  ncpf_pkg::hit_type            hit,
   output logic                         req_full,
   input  ncpf_pkg::queue_status_type   cmd_status,
   output logic                         cmd_push,
   output ncpf_pkg::pair_cmd_type       cmd_data
);
   import ncpf_pkg::*;

   logic                 pending_valid_ff, pending_valid_in;
   hit_type              pending_ff;
   logic                 accept;
   logic                 up_neighbor, down_neighbor, adjacent;
   logic [TIMESTAMP_W:0] diff_up;
   logic [TIMESTAMP_W-1:0] diff_down;

   // The front stalls only when the pair queue has no room.
   assign req_full = cmd_status.full;
   assign accept   = req_push && !cmd_status.full;

   // Channels must differ by exactly one, without wrapping around.
   assign up_neighbor   = ({1'b0, hit.channel} == {1'b0, pending_ff.channel} + 17'd1);
   assign down_neighbor = ({1'b0, pending_ff.channel} == {1'b0, hit.channel} + 17'd1);
   assign adjacent      = pending_valid_ff && (up_neighbor || down_neighbor);

   // Absolute timestamp gap: both differences in parallel, the borrow picks one.
   assign diff_up   = {1'b0, hit.timestamp} - {1'b0, pending_ff.timestamp};
   assign diff_down = pending_ff.timestamp - hit.timestamp;

   // Build the pair command; the pending hit goes out first.
   always_comb begin
      cmd_push            = accept && adjacent;
      cmd_data.first_hit  = pending_ff;
      cmd_data.second_hit = hit;
      cmd_data.gap        = diff_up[TIMESTAMP_W] ? diff_down : diff_up[TIMESTAMP_W-1:0];
      cmd_data.odd_bad    = up_neighbor ? pending_ff.channel[0] : hit.channel[0];
   end

   // A pair consumes the pending hit; any other hit replaces it.
   always_comb begin
      pending_valid_in = pending_valid_ff;
      if (accept) begin
         pending_valid_in = !adjacent;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_valid_ff <= 1'b0;
      end else begin
         pending_valid_ff <= pending_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !adjacent) begin
         pending_ff <= hit;
      end
   end

   `NCPF_ASSERT_IMPLY(front_pair_needs_pending, cmd_push, pending_valid_ff)
   `NCPF_ASSERT_NEXT(front_pair_clears_pending, cmd_push, !pending_valid_ff)

endmodule

FILE: rtl/ncpf_back.sv
// Back end: checks pairs against the window, counts rejects, emits accepted pairs.
`include "neighbor_channel_pair_finder_core_macros.svh"

module ncpf_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [ncpf_pkg::WINDOW_W-1:0]     time_window,
   input  ncpf_pkg::queue_status_type        cmd_status,
   input  ncpf_pkg::pair_cmd_type            cmd_head,
   output logic                              cmd_pop,
   input  ncpf_pkg::queue_status_type        rsp_status,
   output logic                              rsp_push,
   output ncpf_pkg::result_type              rsp_data
);
   import ncpf_pkg::*;

   back_state_type     state_ff, state_in;
   logic [COUNT_W-1:0] odd_ff, odd_in;
   logic [COUNT_W-1:0] gap_ff, gap_in;
   logic [COUNT_W-1:0] total_ff, total_in;
   logic               gap_bad;
   logic               reject;

   assign gap_bad = cmd_head.gap > {{(TIMESTAMP_W - WINDOW_W){1'b0}}, time_window};
   assign reject  = cmd_head.odd_bad || gap_bad;

   // Sequencer: a rejected pair is dropped; an accepted pair is sent hit by hit.
   always_comb begin
      state_in               = state_ff;
      odd_in                 = odd_ff;
      gap_in                 = gap_ff;
      total_in               = total_ff;
      cmd_pop                = 1'b0;
      rsp_push               = 1'b0;
      rsp_data.hit           = cmd_head.first_hit;
      rsp_data.pair_last     = 1'b0;
      rsp_data.odd_rejects   = odd_ff;
      rsp_data.gap_rejects   = gap_ff;
      rsp_data.total_rejects = total_ff;
      case (state_ff)
         BACK_FIRST: begin
            if (!cmd_status.empty) begin
               if (reject) begin
                  if (cmd_head.odd_bad) begin
                     odd_in = sat_inc(odd_ff);
                  end
                  if (gap_bad) begin
                     gap_in = sat_inc(gap_ff);
                  end
                  total_in = sat_inc(total_ff);
                  cmd_pop  = 1'b1;
               end else if (!rsp_status.full) begin
                  rsp_push = 1'b1;
                  state_in = BACK_SECOND;
               end
            end
         end
         BACK_SECOND: begin
            rsp_data.hit       = cmd_head.second_hit;
            rsp_data.pair_last = 1'b1;
            if (!rsp_status.full) begin
               rsp_push = 1'b1;
               cmd_pop  = 1'b1;
               state_in = BACK_FIRST;
            end
         end
         default: begin
            state_in = BACK_FIRST;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_FIRST;
         odd_ff   <= '0;
         gap_ff   <= '0;
         total_ff <= '0;
      end else begin
         state_ff <= state_in;
         odd_ff   <= odd_in;
         gap_ff   <= gap_in;
         total_ff <= total_in;
      end
   end

   `NCPF_ASSERT_IMPLY(back_second_has_pair, state_ff == BACK_SECOND, !cmd_status.empty)
   `NCPF_ASSERT_NEXT(back_first_then_second, (state_ff == BACK_FIRST) && rsp_push, state_ff == BACK_SECOND)
   `NCPF_ASSERT_IMPLY(back_total_covers_causes, 1'b1, (total_ff >= odd_ff) && (total_ff >= gap_ff))

endmodule
